// ===== sv/idle_load_calibrating_monitor_top_macros.svh =====
// assertion macros for the idle load calibrating monitor checker
`ifndef IDLE_LOAD_CALIBRATING_MONITOR_TOP_MACROS_SVH
`define IDLE_LOAD_CALIBRATING_MONITOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ILCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ILCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ilcm_pkg.sv =====
// shared types, constants and microcode table of the idle load monitor
`timescale 1ns / 1ps
package ilcm_pkg;

  localparam int SNAP_W   = 32;
  localparam int ROUNDS_W = 4;
  localparam int DELAY_W  = 20;
  localparam int PCT_W    = 16;
  localparam int CNT_W    = 5;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET    = 4'd3;
  localparam logic [DELAY_W-1:0]  DELAY_AFTER_ALIGN = 20'd100000;
  localparam logic [DELAY_W-1:0]  DELAY_BETWEEN   = 20'd1;
  localparam logic [DELAY_W-1:0]  DELAY_PERIODIC  = 20'd1000000;
  localparam logic [SNAP_W-1:0]   PERCENT_SCALE   = 32'd100;
  localparam logic [CNT_W-1:0]    DIV_LAST_CNT    = 5'd31;

  typedef logic [SNAP_W-1:0] word_t;

  typedef enum logic [1:0] {
    PH_ALIGN   = 2'd0,
    PH_MEASURE = 2'd1,
    PH_SAMPLE  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL_SAMPLE,
    OP_DIV_INIT_SAMPLE,
    OP_DIV_STEP,
    OP_MUL_SCALE,
    OP_DIV_INIT_CALIB,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_NO_INPUT,
    C_ERR,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [3:0] {
    S_WAIT      = 4'd0,
    S_CHECK     = 4'd1,
    S_MUL1      = 4'd2,
    S_DIV1_INIT = 4'd3,
    S_DIV1_STEP = 4'd4,
    S_MUL2      = 4'd5,
    S_DIV2_INIT = 4'd6,
    S_DIV2_STEP = 4'd7,
    S_EMIT      = 4'd8
  } step_t;

  typedef struct packed {
    logic  in_ready;
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic take;
    logic emit;
    logic cfg_we;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic err;
    logic div_more;
    logic out_free;
  } stat_t;

  // control program: jump to target when the condition holds, else step on
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      S_WAIT:      w = '{1'b1, OP_NOP,             C_NO_INPUT, S_WAIT};
      S_CHECK:     w = '{1'b0, OP_NOP,             C_ERR,      S_EMIT};
      S_MUL1:      w = '{1'b0, OP_MUL_SAMPLE,      C_NONE,     S_WAIT};
      S_DIV1_INIT: w = '{1'b0, OP_DIV_INIT_SAMPLE, C_NONE,     S_WAIT};
      S_DIV1_STEP: w = '{1'b0, OP_DIV_STEP,        C_DIV_MORE, S_DIV1_STEP};
      S_MUL2:      w = '{1'b0, OP_MUL_SCALE,       C_NONE,     S_WAIT};
      S_DIV2_INIT: w = '{1'b0, OP_DIV_INIT_CALIB,  C_NONE,     S_WAIT};
      S_DIV2_STEP: w = '{1'b0, OP_DIV_STEP,        C_DIV_MORE, S_DIV2_STEP};
      S_EMIT:      w = '{1'b0, OP_EMIT,            C_OUT_BUSY, S_EMIT};
      default:     w = '{1'b0, OP_NOP,             C_NONE,     S_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/ilcm_if.sv =====
// handshake channel interfaces for activation events and results
`timescale 1ns / 1ps
interface ilcm_in_if;
  logic                       valid;
  logic                       ready;
  logic [ilcm_pkg::SNAP_W-1:0] spin_snapshot;
  logic [ilcm_pkg::SNAP_W-1:0] time_snapshot;

  modport source (output valid, output spin_snapshot, output time_snapshot, input ready);
  modport sink (input valid, input spin_snapshot, input time_snapshot, output ready);
endinterface

interface ilcm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ilcm_pkg::DELAY_W-1:0] next_delay_us;
  logic                         stop_main_loop;
  logic [ilcm_pkg::PCT_W-1:0]   idle_percent;
  logic                         divide_error;
  logic                         calibrated;

  modport source (output valid, output next_delay_us, output stop_main_loop,
                  output idle_percent, output divide_error, output calibrated,
                  input ready);
  modport sink (input valid, input next_delay_us, input stop_main_loop,
                input idle_percent, input divide_error, input calibrated,
                output ready);
endinterface

// ===== sv/ilcm_seq.sv =====
// microcode sequencer: step counter, control table lookup and jumps
`timescale 1ns / 1ps
module ilcm_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            cfg_wr_en,
  input  ilcm_pkg::stat_t stat,
  output logic            in_ready,
  output ilcm_pkg::ctrl_t ctrl
);
  import ilcm_pkg::*;

  step_t  pc_r, pc_nxt;
  ucode_t word;
  logic   hit;

  assign word = ucode_rom(pc_r);

  always_comb begin
    case (word.cond)
      C_NONE:     hit = 1'b0;
      C_NO_INPUT: hit = !in_valid;
      C_ERR:      hit = stat.err;
      C_DIV_MORE: hit = stat.div_more;
      C_OUT_BUSY: hit = !stat.out_free;
      default:    hit = 1'b0;
    endcase
  end

  // program wraps to the wait step after the emit step
  always_comb begin
    if (hit) begin
      pc_nxt = word.target;
    end else if (pc_r == S_EMIT) begin
      pc_nxt = S_WAIT;
    end else begin
      pc_nxt = step_t'(pc_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign in_ready    = word.in_ready;
  assign ctrl.op     = word.op;
  assign ctrl.take   = word.in_ready && in_valid;
  assign ctrl.emit   = (word.op == OP_EMIT) && stat.out_free;
  assign ctrl.cfg_we = cfg_wr_en;

endmodule

// ===== sv/ilcm_dp.sv =====
// datapath: phase state, delta registers, multiplier, serial divider, result register
`timescale 1ns / 1ps
module ilcm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ilcm_pkg::ctrl_t               ctrl,
  input  logic [ilcm_pkg::ROUNDS_W-1:0] cfg_wr_data,
  input  logic [ilcm_pkg::SNAP_W-1:0]   spin_snapshot,
  input  logic [ilcm_pkg::SNAP_W-1:0]   time_snapshot,
  input  logic                          out_ready,
  output ilcm_pkg::stat_t               stat,
  output logic                          out_valid,
  output logic [ilcm_pkg::DELAY_W-1:0]  next_delay_us,
  output logic                          stop_main_loop,
  output logic [ilcm_pkg::PCT_W-1:0]    idle_percent,
  output logic                          divide_error,
  output logic                          calibrated
);
  import ilcm_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [ROUNDS_W-1:0] rounds_left_r, rounds_left_nxt;
  word_t               last_spins_r, prev_stamp_r;
  word_t               cal_spins_r, cal_span_r, smp_spins_r, smp_span_r;
  logic [DELAY_W-1:0]  delay_d, delay_r;
  logic                stop_d, stop_r, calib_r;

  word_t               acc_r, rem_r, quo_r, dvs_r;
  logic [CNT_W-1:0]    cnt_r;
  word_t               prod;
  logic [SNAP_W:0]     trial, diff;
  logic                ge;
  logic                err;

  logic                out_valid_r, stop_out_r, err_out_r, calib_out_r;
  logic [DELAY_W-1:0]  delay_out_r;
  logic [PCT_W-1:0]    pct_out_r;

  // phase machine next state
  always_comb begin
    phase_nxt       = phase_r;
    rounds_left_nxt = rounds_left_r;
    if (ctrl.take) begin
      case (phase_r)
        PH_ALIGN: begin
          phase_nxt = PH_MEASURE;
        end
        PH_MEASURE: begin
          if (rounds_left_r > 4'd1) begin
            rounds_left_nxt = rounds_left_r - 4'd1;
            phase_nxt       = PH_ALIGN;
          end else begin
            rounds_left_nxt = '0;
            phase_nxt       = PH_SAMPLE;
          end
        end
        default: begin
          phase_nxt = PH_SAMPLE;
        end
      endcase
    end
    if (ctrl.cfg_we) begin
      rounds_left_nxt = cfg_wr_data;
    end
  end

  // phase machine outputs for the transaction
  always_comb begin
    delay_d = DELAY_PERIODIC;
    stop_d  = 1'b0;
    case (phase_r)
      PH_ALIGN: begin
        delay_d = DELAY_AFTER_ALIGN;
      end
      PH_MEASURE: begin
        if (rounds_left_r > 4'd1) begin
          delay_d = DELAY_BETWEEN;
        end else begin
          stop_d = 1'b1;
        end
      end
      default: begin
        delay_d = DELAY_PERIODIC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_ALIGN;
      rounds_left_r <= ROUNDS_RESET;
      last_spins_r  <= '0;
      prev_stamp_r  <= '0;
      cal_spins_r   <= '0;
      cal_span_r    <= '0;
      smp_spins_r   <= '0;
      smp_span_r    <= '0;
    end else begin
      phase_r       <= phase_nxt;
      rounds_left_r <= rounds_left_nxt;
      if (ctrl.take) begin
        last_spins_r <= spin_snapshot;
        prev_stamp_r <= time_snapshot;
        if (phase_r == PH_MEASURE) begin
          cal_spins_r <= spin_snapshot - last_spins_r;
          cal_span_r  <= time_snapshot - prev_stamp_r;
        end else if (phase_r != PH_ALIGN) begin
          smp_spins_r <= spin_snapshot - last_spins_r;
          smp_span_r  <= time_snapshot - prev_stamp_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      delay_r <= delay_d;
      stop_r  <= stop_d;
      calib_r <= (phase_nxt == PH_SAMPLE);
    end
  end

  assign err = (smp_span_r == '0) || (cal_spins_r == '0);

  // only the low word of each product is kept
  always_comb begin
    if (ctrl.op == OP_MUL_SCALE) begin
      prod = quo_r * PERCENT_SCALE;
    end else begin
      prod = smp_spins_r * cal_span_r;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_r, quo_r[SNAP_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = !diff[SNAP_W];

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_MUL_SAMPLE, OP_MUL_SCALE: begin
        acc_r <= prod;
      end
      OP_DIV_INIT_SAMPLE: begin
        quo_r <= acc_r;
        rem_r <= '0;
        dvs_r <= smp_span_r;
        cnt_r <= '0;
      end
      OP_DIV_INIT_CALIB: begin
        quo_r <= acc_r;
        rem_r <= '0;
        dvs_r <= cal_spins_r;
        cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? diff[SNAP_W-1:0] : trial[SNAP_W-1:0];
        quo_r <= {quo_r[SNAP_W-2:0], ge};
        cnt_r <= cnt_r + 5'd1;
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign stat.err      = err;
  assign stat.div_more = (cnt_r != DIV_LAST_CNT);
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      delay_out_r <= delay_r;
      stop_out_r  <= stop_r;
      pct_out_r   <= err ? '0 : quo_r[PCT_W-1:0];
      err_out_r   <= err;
      calib_out_r <= calib_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign next_delay_us  = delay_out_r;
  assign stop_main_loop = stop_out_r;
  assign idle_percent   = pct_out_r;
  assign divide_error   = err_out_r;
  assign calibrated     = calib_out_r;

endmodule

// ===== sv/idle_load_calibrating_monitor_top.sv =====
// top level of the idle load calibrating monitor
// a transaction runs through the check, multiply, divide, scale, divide and emit steps; a
// zero divisor jumps from the check step to emit; the next input is taken only after emit; the
// two 32-step serial divisions share one divider run by the microcode sequencer
// a held result does not block the next input transaction
// reset (rst_n low, synchronous): align phase, 3 rounds, deltas and snapshots zero
`timescale 1ns / 1ps
module idle_load_calibrating_monitor_top (
  input  logic                          clk,
  input  logic                          rst_n,
  ilcm_in_if.sink                       in_ch,
  ilcm_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [ilcm_pkg::ROUNDS_W-1:0] cfg_wr_data
);
  import ilcm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ilcm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .cfg_wr_en (cfg_wr_en),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .ctrl      (ctrl)
  );

  ilcm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .cfg_wr_data    (cfg_wr_data),
    .spin_snapshot  (in_ch.spin_snapshot),
    .time_snapshot  (in_ch.time_snapshot),
    .out_ready      (out_ch.ready),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .next_delay_us  (out_ch.next_delay_us),
    .stop_main_loop (out_ch.stop_main_loop),
    .idle_percent   (out_ch.idle_percent),
    .divide_error   (out_ch.divide_error),
    .calibrated     (out_ch.calibrated)
  );

endmodule

// ===== sv/ilcm_chk.sv =====
// port-level checker for the result channel, bound to the top level
`timescale 1ns / 1ps
`include "idle_load_calibrating_monitor_top_macros.svh"
module ilcm_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ilcm_pkg::DELAY_W-1:0] out_delay,
  input logic                         out_stop,
  input logic [ilcm_pkg::PCT_W-1:0]   out_pct,
  input logic                         out_err,
  input logic                         out_cal
);
  import ilcm_pkg::*;

  logic stop_legal;
  logic delay_legal;

  assign stop_legal  = out_cal && (out_delay == DELAY_PERIODIC);
  assign delay_legal = (out_delay == DELAY_PERIODIC) || (out_delay == DELAY_AFTER_ALIGN) ||
                       (out_delay == DELAY_BETWEEN);

  `ILCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
  `ILCM_ASSERT_NOW(a_err_zero, out_valid && out_err, out_pct == '0, "error with nonzero percent")
  `ILCM_ASSERT_NOW(a_stop_cal, out_valid && out_stop, stop_legal, "stop without entering sampling")
  `ILCM_ASSERT_NOW(a_delay_set, out_valid, delay_legal, "unexpected delay value")

endmodule

bind idle_load_calibrating_monitor_top ilcm_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_delay (out_ch.next_delay_us),
  .out_stop  (out_ch.stop_main_loop),
  .out_pct   (out_ch.idle_percent),
  .out_err   (out_ch.divide_error),
  .out_cal   (out_ch.calibrated)
);

// ===== verif/idle_load_calibrating_monitor_top_tb.sv =====
// self-checking testbench for the idle load calibrating monitor: calibration, sampling, stalls
`timescale 1ns / 1ps
module idle_load_calibrating_monitor_top_tb;
  import ilcm_pkg::*;

  typedef struct packed {
    logic [DELAY_W-1:0] next_delay_us;
    logic               stop_main_loop;
    logic [PCT_W-1:0]   idle_percent;
    logic               divide_error;
    logic               calibrated;
  } idle_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [ROUNDS_W-1:0] cfg_wr_data;

  ilcm_in_if  in_ch ();
  ilcm_out_if out_ch ();

  idle_load_calibrating_monitor_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted monitor state
  phase_t              mon_phase   = PH_ALIGN;
  logic [ROUNDS_W-1:0] rounds_left = ROUNDS_RESET;
  word_t last_spin    = '0;
  word_t prev_stamp   = '0;
  word_t cal_spins    = '0;
  word_t cal_span     = '0;
  word_t smp_spins    = '0;
  word_t smp_span     = '0;

  idle_report_t pending_reports[$];
  int    mismatches = 0;
  int    burst_left = 0;
  int    sink_run   = 0;
  logic  in_offered = 1'b0;
  word_t spin_now   = '0;
  word_t time_now   = '0;

  function automatic idle_report_t predict_idle_report(input word_t spin, input word_t now);
    idle_report_t r;
    word_t        x;
    r = '0;
    case (mon_phase)
      PH_ALIGN: begin
        mon_phase = PH_MEASURE;
        r.next_delay_us = DELAY_AFTER_ALIGN;
      end
      PH_MEASURE: begin
        cal_spins = spin - last_spin;
        cal_span  = now - prev_stamp;
        if (rounds_left > 1) begin
          rounds_left = rounds_left - 1'b1;
          mon_phase = PH_ALIGN;
          r.next_delay_us = DELAY_BETWEEN;
        end else begin
          // zero rounds behaves like one, counter never wraps
          rounds_left = '0;
          mon_phase = PH_SAMPLE;
          r.next_delay_us = DELAY_PERIODIC;
          r.stop_main_loop = 1'b1;
        end
      end
      default: begin
        smp_spins = spin - last_spin;
        smp_span  = now - prev_stamp;
        r.next_delay_us = DELAY_PERIODIC;
      end
    endcase
    last_spin  = spin;
    prev_stamp = now;
    if (smp_span == '0 || cal_spins == '0) begin
      r.divide_error = 1'b1;
    end else begin
      x = smp_spins * cal_span;
      x = x / smp_span;
      x = x * PERCENT_SCALE;
      x = x / cal_spins;
      r.idle_percent = x[PCT_W-1:0];
    end
    r.calibrated = (mon_phase == PH_SAMPLE);
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // receiver back-pressure: free-flowing stretches, long stalls and choppy runs
  always @(posedge clk) begin
    if (sink_run == 0) begin
      case ($urandom_range(0, 7))
        0: begin
          out_ch.ready <= 1'b1;
          sink_run <= $urandom_range(200, 600);
        end
        1, 2: begin
          out_ch.ready <= 1'b0;
          sink_run <= $urandom_range(20, 160);
        end
        default: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
          sink_run <= $urandom_range(0, 12);
        end
      endcase
    end else begin
      sink_run <= sink_run - 1;
    end
  end

  always @(posedge clk) begin : report_check
    idle_report_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transaction with nothing expected, idle_percent %0d",
                 $time, out_ch.idle_percent);
      end else begin
        want = pending_reports.pop_front();
        check_field("next_delay_us", 32'(want.next_delay_us), 32'(out_ch.next_delay_us));
        check_field("stop_main_loop", 32'(want.stop_main_loop), 32'(out_ch.stop_main_loop));
        check_field("idle_percent", 32'(want.idle_percent), 32'(out_ch.idle_percent));
        check_field("divide_error", 32'(want.divide_error), 32'(out_ch.divide_error));
        check_field("calibrated", 32'(want.calibrated), 32'(out_ch.calibrated));
      end
    end
  end

  // bursts of random length with idle gaps; junk rides on the bus while valid is low
  task automatic pace_sender();
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap != 0) begin
      if (in_offered) begin
        in_ch.valid <= 1'b0;
        in_offered = 1'b0;
      end
      in_ch.spin_snapshot <= $urandom;
      in_ch.time_snapshot <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_activation(input word_t spin, input word_t now);
    pace_sender();
    in_ch.valid         <= 1'b1;
    in_ch.spin_snapshot <= spin;
    in_ch.time_snapshot <= now;
    in_offered = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_reports.push_back(predict_idle_report(spin, now));
    spin_now = spin;
    time_now = now;
  endtask

  task automatic wait_all_reports();
    if (in_offered) begin
      in_ch.valid <= 1'b0;
      in_offered = 1'b0;
    end
    while (pending_reports.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_rounds(input logic [ROUNDS_W-1:0] value);
    wait_all_reports();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rounds_left = value;
  endtask

  // roughly one second of activity at the calibrated spin rate
  task automatic send_typical_second();
    longint unsigned per_sec;
    per_sec = longint'(cal_spins) * 10;
    send_activation(spin_now + word_t'((per_sec * $urandom_range(0, 105)) / 100),
                    time_now + 32'd998000 + $urandom_range(0, 4000));
  endtask

  task automatic apply_reset();
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.spin_snapshot <= '0;
    in_ch.time_snapshot <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_calibration();
    write_rounds(4'd15);
    send_activation('0, '0);
    // no spins during the measure: calibration divisor is zero
    send_activation('0, 32'd100000);
    send_activation('1, '1);
    send_activation(32'h0000_3fff, 32'd99999);
    write_rounds(4'd2);
    send_activation(32'h1234_5678, 32'h8000_0000);
    send_activation(32'h1234_5678 + 32'd777, 32'h8000_0000 + 32'd100001);
    send_activation(32'h2000_0000, 32'h9000_0000);
    // reload with zero while measuring: the next measure is the last one
    write_rounds(4'd0);
    send_activation(32'h2000_0000 + $urandom_range(5000, 900000),
                    32'h9000_0000 + 32'd100000 + $urandom_range(0, 50));
  endtask

  task automatic test_sample_corners();
    send_activation(spin_now, time_now);
    send_activation(spin_now + 32'd5, time_now);
    send_activation(spin_now, time_now + 32'd1000000);
    send_activation(spin_now + 32'hffff_ffff, time_now + 32'd1);
    send_activation('0, '0);
    send_activation('1, '1);
    send_typical_second();
    write_rounds(4'd1);
    write_rounds(4'd15);
    send_typical_second();
    send_typical_second();
  endtask

  task automatic test_random_activity(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        send_typical_second();
      end else if (pick < 14) begin
        send_activation($urandom, $urandom);
      end else if (pick == 14) begin
        send_activation(spin_now + $urandom_range(0, 50000), time_now);
      end else if (pick == 15) begin
        send_activation(spin_now, time_now);
      end else if (pick < 18) begin
        send_activation(spin_now + $urandom_range(0, 255), time_now + $urandom_range(1, 255));
      end else if (pick == 18) begin
        // land just below the wrap point of both counters
        send_activation(32'hffff_ffff - $urandom_range(0, 3000000),
                        32'hffff_ffff - $urandom_range(0, 3000000));
      end else begin
        send_activation(spin_now + $urandom_range(0, 20), time_now + 32'd1);
      end
      if (i % 250 == 249)
        write_rounds(4'($urandom_range(0, 15)));
      else if ($urandom_range(0, 99) == 0)
        wait_all_reports();
    end
  endtask

  task automatic finish_run();
    wait_all_reports();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  endtask

  initial begin
    apply_reset();
    test_calibration();
    test_sample_corners();
    test_random_activity(1430);
    finish_run();
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ilcm_pkg.sv
sv/ilcm_if.sv
sv/ilcm_seq.sv
sv/ilcm_dp.sv
sv/idle_load_calibrating_monitor_top.sv
sv/ilcm_chk.sv
verif/idle_load_calibrating_monitor_top_tb.sv
